// ----- sv/stereo_preamp_highpass_limiter_defines.svh -----
// Assertion macros shared by the stereo preamp / high-pass / limiter RTL.
// Depends on nothing; files that assert include it by bare name.
`ifndef STEREO_PREAMP_HIGHPASS_LIMITER_DEFINES_SVH
`define STEREO_PREAMP_HIGHPASS_LIMITER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/spl_pkg.sv -----
// Shared types and constants for the stereo preamp / high-pass / limiter.
// No dependencies.
`timescale 1ns / 1ps

package spl_pkg;

  localparam int GAIN_FRAC  = 15;
  localparam int ALPHA_FRAC = 16;

  localparam int GAIN_BITS  = 16;
  localparam int ALPHA_BITS = 16;
  localparam int CEIL_BITS  = 23;

  localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = 16'd16423;
  localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 16'd64522;
  localparam logic [CEIL_BITS-1:0]  CEIL_RESET  = 23'd7476408;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_GAIN   = 2'd0;
  localparam logic [1:0] REG_ALPHA  = 2'd1;
  localparam logic [1:0] REG_CEIL   = 2'd2;
  localparam logic [1:0] REG_BYPASS = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN_L,
    ST_GAIN_R,
    ST_ALPHA_L,
    ST_ALPHA_R,
    ST_DONE,
    ST_BYPASS
  } state_t;

  typedef enum logic [1:0] {
    MUL_GAIN_L,
    MUL_GAIN_R,
    MUL_ALPHA_L,
    MUL_ALPHA_R
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     scale_l;
    logic     scale_r;
    logic     filt_l;
    logic     write_out;
    logic     write_bypass;
  } spl_cmd_t;

endpackage

// ----- sv/spl_ctrl.sv -----
// Sequencing controller: steps one frame through the shared multiplier.
// Depends on spl_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "stereo_preamp_highpass_limiter_defines.svh"

module spl_ctrl
  import spl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  logic     bypass_on,
  output spl_cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid_next;
  logic   slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.mul_sel    = MUL_GAIN_L;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = bypass_on ? ST_BYPASS : ST_GAIN_L;
        end
      end
      ST_GAIN_L: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GAIN_L;
        state_next  = ST_GAIN_R;
      end
      ST_GAIN_R: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GAIN_R;
        cmd.scale_l = 1'b1;
        state_next  = ST_ALPHA_L;
      end
      ST_ALPHA_L: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ALPHA_L;
        cmd.scale_r = 1'b1;
        state_next  = ST_ALPHA_R;
      end
      ST_ALPHA_R: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ALPHA_R;
        cmd.filt_l  = 1'b1;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        // The right filter product stays in the product register until
        // the output word can be loaded.
        if (slot_free) begin
          cmd.write_out  = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_BYPASS: begin
        if (slot_free) begin
          cmd.write_bypass = 1'b1;
          out_valid_next   = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `SPL_ASSERT_NEXT(a_proc_start, in_valid && !in_stall && !bypass_on, state == ST_GAIN_L, "processed word did not start with the left gain step")
  `SPL_ASSERT_NEXT(a_done_loads, state == ST_DONE && !out_valid, out_valid && state == ST_IDLE, "finished word was not presented")
  `SPL_ASSERT_NEXT(a_held_word, out_valid && out_stall && state == ST_DONE, state == ST_DONE && out_valid, "pending word overwritten while stalled")
  `SPL_ASSERT_NOW(a_one_load, cmd.write_out || cmd.write_bypass, !(cmd.write_out && cmd.write_bypass) && slot_free, "output load without a free slot")

endmodule

// ----- sv/spl_datapath.sv -----
// Datapath: sample and filter state, one shared multiplier, rounding,
// saturation and the limiter. Depends on spl_pkg; driven by spl_ctrl.
`timescale 1ns / 1ps

module spl_datapath
  import spl_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  spl_cmd_t                      cmd,
  input  logic        [GAIN_BITS-1:0]   input_gain,
  input  logic        [ALPHA_BITS-1:0]  highpass_alpha,
  input  logic        [CEIL_BITS-1:0]   limit_ceiling,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out
);

  localparam int FILT = SAMPLE_BITS + 2;
  localparam int AW   = SAMPLE_BITS + 3;
  localparam int PW   = AW + ALPHA_BITS + 1;

  localparam logic signed [PW:0] ONE   = 1;
  localparam logic signed [PW:0] S_MAX = (ONE <<< (SAMPLE_BITS - 1)) - ONE;
  localparam logic signed [PW:0] S_MIN = -S_MAX - ONE;
  localparam logic signed [PW:0] F_MAX = (ONE <<< (FILT - 1)) - ONE;
  localparam logic signed [PW:0] F_MIN = -F_MAX - ONE;
  localparam logic [32:0] CAP_MAX = (33'd1 << (SAMPLE_BITS - 1)) - 33'd1;

  logic signed [SAMPLE_BITS-1:0] x_l, x_r;
  logic signed [SAMPLE_BITS-1:0] last_scaled_l, last_scaled_r;
  logic signed [FILT-1:0]        last_filt_l, last_filt_r;
  logic signed [AW-1:0]          sum_l, sum_r;
  logic signed [SAMPLE_BITS-1:0] clip_l;
  logic signed [PW-1:0]          prod;

  logic signed [AW-1:0]          mul_a;
  logic signed [ALPHA_BITS:0]    mul_b;
  logic signed [PW:0]            rnd_g, sh_g, rnd_a, sh_a;
  logic signed [SAMPLE_BITS-1:0] scaled_w;
  logic signed [FILT-1:0]        filt_w;
  logic        [32:0]            cap;
  logic signed [FILT-1:0]        ceil_f;
  logic signed [FILT-1:0]        clip_w;

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_GAIN_L:  mul_a = AW'(x_l);
      MUL_GAIN_R:  mul_a = AW'(x_r);
      MUL_ALPHA_L: mul_a = sum_l;
      MUL_ALPHA_R: mul_a = sum_r;
      default:     mul_a = sum_r;
    endcase
    if (cmd.mul_sel == MUL_GAIN_L || cmd.mul_sel == MUL_GAIN_R) begin
      mul_b = {1'b0, input_gain};
    end else begin
      mul_b = {1'b0, highpass_alpha};
    end
  end

  // Round half up, then saturate: gain result to the sample range,
  // filter result to the wider state range.
  always_comb begin
    rnd_g = {prod[PW-1], prod} + (ONE <<< (GAIN_FRAC - 1));
    sh_g  = rnd_g >>> GAIN_FRAC;
    if (sh_g > S_MAX) begin
      scaled_w = S_MAX[SAMPLE_BITS-1:0];
    end else if (sh_g < S_MIN) begin
      scaled_w = S_MIN[SAMPLE_BITS-1:0];
    end else begin
      scaled_w = sh_g[SAMPLE_BITS-1:0];
    end

    rnd_a = {prod[PW-1], prod} + (ONE <<< (ALPHA_FRAC - 1));
    sh_a  = rnd_a >>> ALPHA_FRAC;
    if (sh_a > F_MAX) begin
      filt_w = F_MAX[FILT-1:0];
    end else if (sh_a < F_MIN) begin
      filt_w = F_MIN[FILT-1:0];
    end else begin
      filt_w = sh_a[FILT-1:0];
    end
  end

  // The ceiling never exceeds the largest positive sample.
  always_comb begin
    cap    = (33'(limit_ceiling) > CAP_MAX) ? CAP_MAX : 33'(limit_ceiling);
    ceil_f = {3'b000, cap[SAMPLE_BITS-2:0]};
    if (filt_w > ceil_f) begin
      clip_w = ceil_f;
    end else if (filt_w < -ceil_f) begin
      clip_w = -ceil_f;
    end else begin
      clip_w = filt_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_scaled_l <= '0;
      last_scaled_r <= '0;
      last_filt_l   <= '0;
      last_filt_r   <= '0;
    end else begin
      if (cmd.scale_l) begin
        last_scaled_l <= scaled_w;
      end
      if (cmd.scale_r) begin
        last_scaled_r <= scaled_w;
      end
      if (cmd.filt_l) begin
        last_filt_l <= filt_w;
      end
      if (cmd.write_out) begin
        last_filt_r <= filt_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_l <= left_sample;
      x_r <= right_sample;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.scale_l) begin
      sum_l <= AW'(last_filt_l) + AW'(scaled_w) - AW'(last_scaled_l);
    end
    if (cmd.scale_r) begin
      sum_r <= AW'(last_filt_r) + AW'(scaled_w) - AW'(last_scaled_r);
    end
    if (cmd.filt_l) begin
      clip_l <= clip_w[SAMPLE_BITS-1:0];
    end
    if (cmd.write_out) begin
      left_out  <= clip_l;
      right_out <= clip_w[SAMPLE_BITS-1:0];
    end else if (cmd.write_bypass) begin
      left_out  <= x_l;
      right_out <= x_r;
    end
  end

endmodule

// ----- sv/stereo_preamp_highpass_limiter.sv -----
// Stereo preamp, first-order high-pass and hard limiter. An input word is
// taken only while the block is idle; a processed frame then takes four
// multiply steps on the single shared multiplier plus one output load, and
// no new frame is accepted before that load. Bypassed frames skip the
// multiply steps. The finished word sits in an output register while the
// next frame is accepted; a stall holds only the final load.
// Configuration registers sit on the APB port at byte addresses 0, 4, 8, 12:
// preamp gain (Q1.15), high-pass alpha (Q0.16), limiter ceiling, bypass.
`timescale 1ns / 1ps

module stereo_preamp_highpass_limiter
  import spl_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out
);

  logic [GAIN_BITS-1:0]  input_gain;
  logic [ALPHA_BITS-1:0] highpass_alpha;
  logic [CEIL_BITS-1:0]  limit_ceiling;
  logic                  bypass_on;
  logic [1:0]            reg_index;
  logic                  cfg_write;
  spl_cmd_t              cmd;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_gain     <= GAIN_RESET;
      highpass_alpha <= ALPHA_RESET;
      limit_ceiling  <= CEIL_RESET;
      bypass_on      <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_GAIN:   input_gain     <= pwdata[GAIN_BITS-1:0];
        REG_ALPHA:  highpass_alpha <= pwdata[ALPHA_BITS-1:0];
        REG_CEIL:   limit_ceiling  <= pwdata[CEIL_BITS-1:0];
        REG_BYPASS: bypass_on      <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_GAIN:   prdata = 32'(input_gain);
      REG_ALPHA:  prdata = 32'(highpass_alpha);
      REG_CEIL:   prdata = 32'(limit_ceiling);
      REG_BYPASS: prdata = 32'(bypass_on);
      default:    prdata = '0;
    endcase
  end

  spl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .bypass_on (bypass_on),
    .cmd       (cmd)
  );

  spl_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .input_gain     (input_gain),
    .highpass_alpha (highpass_alpha),
    .limit_ceiling  (limit_ceiling),
    .left_sample    (left_sample),
    .right_sample   (right_sample),
    .left_out       (left_out),
    .right_out      (right_out)
  );

endmodule
